// ===== rtl/ngga_pkg.sv =====
// Shared types and constants for the GGA position parser.
// Holds character codes, status codes and the result struct; no dependencies.
package ngga_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNAVAIL = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  localparam int LAT_W  = 27;
  localparam int LON_W  = 31;

  localparam int unsigned UNITS_PER_DEG = 600000;

  typedef struct packed {
    logic [1:0]       status;
    logic [LAT_W-1:0] latitude;
    logic [LON_W-1:0] longitude;
  } ngga_result_t;

endpackage

// ===== rtl/ngga_parser.sv =====
// Per-byte sentence parser: header hunt, field counting, digit accumulation.
// Produces one result beat on timeout or at the end of the E/W field. Uses ngga_pkg.
module ngga_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  output logic                 res_valid,
  output ngga_pkg::ngga_result_t res
);

  localparam logic [2:0] ST_HUNT   = 3'd0;
  localparam logic [2:0] ST_DOLLAR = 3'd1;
  localparam logic [2:0] ST_G1     = 3'd2;
  localparam logic [2:0] ST_P      = 3'd3;
  localparam logic [2:0] ST_G2     = 3'd4;
  localparam logic [2:0] ST_G3     = 3'd5;
  localparam logic [2:0] ST_HDR    = 3'd6;
  localparam logic [2:0] ST_BODY   = 3'd7;

  localparam logic [2:0] FLD_TIME = 3'd0;
  localparam logic [2:0] FLD_LAT  = 3'd1;
  localparam logic [2:0] FLD_NS   = 3'd2;
  localparam logic [2:0] FLD_LON  = 3'd3;
  localparam logic [2:0] FLD_EW   = 3'd4;

  localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
  localparam logic [3:0] LON_DEG_DIGITS = 4'd3;
  localparam logic [3:0] MIN_DIGITS     = 4'd6;

  localparam int LAT_W = ngga_pkg::LAT_W;
  localparam int LON_W = ngga_pkg::LON_W;

  logic [2:0]  stage_r, stage_nxt;
  logic [2:0]  fld_r, fld_nxt;
  logic [3:0]  cpos_r, cpos_nxt;
  logic [6:0]  lat_deg_r, lat_deg_nxt;
  logic [19:0] lat_min_r, lat_min_nxt;
  logic [9:0]  lon_deg_r, lon_deg_nxt;
  logic [19:0] lon_min_r, lon_min_nxt;
  logic [1:0]  hemi_r, hemi_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] limit_r;

  // Scale the minute digits so that missing trailing digits weigh as zeros.
  function automatic logic [19:0] scale_min(input logic [19:0] mn, input logic [3:0] cp,
                                             input logic [3:0] dd);
    logic [3:0]  m;
    logic [39:0] prod;
    m = (cp > dd) ? (cp - dd) : 4'd0;
    if (m > MIN_DIGITS) m = MIN_DIGITS;
    unique case (m[2:0])
      3'd0:    prod = 40'(mn) * 40'd1000000;
      3'd1:    prod = 40'(mn) * 40'd100000;
      3'd2:    prod = 40'(mn) * 40'd10000;
      3'd3:    prod = 40'(mn) * 40'd1000;
      3'd4:    prod = 40'(mn) * 40'd100;
      3'd5:    prod = 40'(mn) * 40'd10;
      default: prod = 40'(mn);
    endcase
    return prod[19:0];
  endfunction

  logic        is_dollar, is_comma, is_digit;
  logic [3:0]  dval;
  logic [2:0]  eff_stage, hunt_stage;
  logic [15:0] cnt_inc;
  logic        emit, timeout;
  logic [LAT_W-1:0] lat_mag;
  logic [LON_W-1:0] lon_mag;

  assign is_dollar = (rx_byte == ngga_pkg::CH_DOLLAR);
  assign is_comma  = (rx_byte == ngga_pkg::CH_COMMA);
  assign is_digit  = (rx_byte >= ngga_pkg::CH_ZERO) && (rx_byte <= ngga_pkg::CH_NINE);
  assign dval      = rx_byte[3:0];
  assign cnt_inc   = cnt_r + 16'd1;

  // A dollar inside or right after the header restarts the hunt.
  always_comb begin
    eff_stage = stage_r;
    if (stage_r >= ST_HDR && is_dollar) eff_stage = ST_HUNT;
    if (eff_stage == ST_HDR && !is_comma) eff_stage = ST_HUNT;
  end

  always_comb begin
    priority if (is_dollar) hunt_stage = ST_DOLLAR;
    else if (rx_byte == ngga_pkg::CH_G &&
             (eff_stage == ST_DOLLAR || eff_stage == ST_P || eff_stage == ST_G2))
      hunt_stage = eff_stage + 3'd1;
    else if (rx_byte == ngga_pkg::CH_P && eff_stage == ST_G1) hunt_stage = ST_P;
    else if (rx_byte == ngga_pkg::CH_A && eff_stage == ST_G3) hunt_stage = ST_HDR;
    else hunt_stage = ST_HUNT;
  end

  always_comb begin
    stage_nxt   = stage_r;
    fld_nxt     = fld_r;
    cpos_nxt    = cpos_r;
    lat_deg_nxt = lat_deg_r;
    lat_min_nxt = lat_min_r;
    lon_deg_nxt = lon_deg_r;
    lon_min_nxt = lon_min_r;
    hemi_nxt    = hemi_r;
    seen_nxt    = seen_r;
    bad_nxt     = bad_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    timeout     = 1'b0;

    if (eff_stage == ST_HDR) begin
      stage_nxt   = ST_BODY;
      fld_nxt     = FLD_TIME;
      cpos_nxt    = 4'd0;
      lat_deg_nxt = '0;
      lat_min_nxt = '0;
      lon_deg_nxt = '0;
      lon_min_nxt = '0;
      hemi_nxt    = 2'b11;
      seen_nxt    = 2'b00;
      bad_nxt     = 1'b0;
    end else if (eff_stage == ST_BODY) begin
      if (is_comma) begin
        // Pad the closing position field, then advance.
        if (fld_r == FLD_LAT) begin
          if (cpos_r == 4'd0) lat_deg_nxt = 7'(11'(lat_deg_r) * 11'd100);
          else if (cpos_r == 4'd1) lat_deg_nxt = 7'(11'(lat_deg_r) * 11'd10);
          lat_min_nxt = scale_min(lat_min_r, cpos_r, LAT_DEG_DIGITS);
        end else if (fld_r == FLD_LON) begin
          if (cpos_r == 4'd0) lon_deg_nxt = 10'(20'(lon_deg_r) * 20'd1000);
          else if (cpos_r == 4'd1) lon_deg_nxt = 10'(20'(lon_deg_r) * 20'd100);
          else if (cpos_r == 4'd2) lon_deg_nxt = 10'(20'(lon_deg_r) * 20'd10);
          lon_min_nxt = scale_min(lon_min_r, cpos_r, LON_DEG_DIGITS);
        end
        fld_nxt  = fld_r + 3'd1;
        cpos_nxt = 4'd0;
        if (fld_r == FLD_EW) begin
          emit      = 1'b1;
          stage_nxt = ST_HUNT;
          cnt_nxt   = '0;
        end
      end else if (fld_r == FLD_LAT || fld_r == FLD_LON) begin
        if (is_digit) begin
          if (fld_r == FLD_LAT) begin
            if (cpos_r < LAT_DEG_DIGITS)
              lat_deg_nxt = 7'(11'(lat_deg_r) * 11'd10 + 11'(dval));
            else if (cpos_r < LAT_DEG_DIGITS + MIN_DIGITS)
              lat_min_nxt = 20'(24'(lat_min_r) * 24'd10 + 24'(dval));
            seen_nxt[0] = 1'b1;
          end else begin
            if (cpos_r < LON_DEG_DIGITS)
              lon_deg_nxt = 10'(14'(lon_deg_r) * 14'd10 + 14'(dval));
            else if (cpos_r < LON_DEG_DIGITS + MIN_DIGITS)
              lon_min_nxt = 20'(24'(lon_min_r) * 24'd10 + 24'(dval));
            seen_nxt[1] = 1'b1;
          end
          if (cpos_r != 4'd15) cpos_nxt = cpos_r + 4'd1;
        end else if (rx_byte != ngga_pkg::CH_DOT) begin
          bad_nxt = 1'b1;
        end
      end else if (fld_r == FLD_NS) begin
        hemi_nxt[0] = (rx_byte == ngga_pkg::CH_N);
      end else if (fld_r == FLD_EW) begin
        hemi_nxt[1] = (rx_byte == ngga_pkg::CH_E);
      end
    end else begin
      stage_nxt = hunt_stage;
      if (hunt_stage == ST_HDR) begin
        cnt_nxt = '0;
      end else if (cnt_inc >= limit_r) begin
        cnt_nxt   = '0;
        stage_nxt = ST_HUNT;
        timeout   = 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  assign lat_mag = LAT_W'(lat_deg_r) * LAT_W'(ngga_pkg::UNITS_PER_DEG) + LAT_W'(lat_min_r);
  assign lon_mag = LON_W'(lon_deg_r) * LON_W'(ngga_pkg::UNITS_PER_DEG) + LON_W'(lon_min_r);

  always_comb begin
    res = '0;
    if (timeout) begin
      res.status = ngga_pkg::STAT_TIMEOUT;
    end else if (seen_r != 2'b11) begin
      res.status = ngga_pkg::STAT_UNAVAIL;
    end else if (bad_r) begin
      res.status = ngga_pkg::STAT_BAD;
    end else begin
      res.status    = ngga_pkg::STAT_OK;
      res.latitude  = hemi_r[0] ? lat_mag : (LAT_W'(0) - lat_mag);
      res.longitude = hemi_r[1] ? lon_mag : (LON_W'(0) - lon_mag);
    end
  end

  assign res_valid = beat && (emit || timeout);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_HUNT;
      fld_r     <= FLD_TIME;
      cpos_r    <= '0;
      lat_deg_r <= '0;
      lat_min_r <= '0;
      lon_deg_r <= '0;
      lon_min_r <= '0;
      hemi_r    <= 2'b11;
      seen_r    <= '0;
      bad_r     <= 1'b0;
      cnt_r     <= '0;
      limit_r   <= 16'd599;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (beat) begin
        stage_r   <= stage_nxt;
        fld_r     <= fld_nxt;
        cpos_r    <= cpos_nxt;
        lat_deg_r <= lat_deg_nxt;
        lat_min_r <= lat_min_nxt;
        lon_deg_r <= lon_deg_nxt;
        lon_min_r <= lon_min_nxt;
        hemi_r    <= hemi_nxt;
        seen_r    <= seen_nxt;
        bad_r     <= bad_nxt;
        cnt_r     <= cnt_nxt;
      end
    end
  end

endmodule

// ===== rtl/ngga_out_buf.sv =====
// Result register with a skid stage, so input keeps flowing while a result waits.
// Uses ngga_pkg for the result struct.
module ngga_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ngga_pkg::ngga_result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ngga_pkg::ngga_result_t out_data
);

  logic                   out_valid_r;
  logic                   skid_valid_r;
  ngga_pkg::ngga_result_t out_data_r;
  ngga_pkg::ngga_result_t skid_data_r;
  logic                   pop;

  assign pop       = out_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Drain the skid entry first; no push can arrive while it is full.
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_data_r <= skid_data_r;
    end else if (push) begin
      if (!out_valid_r || pop) out_data_r <= push_data;
      else skid_data_r <= push_data;
    end
  end

endmodule

// ===== rtl/nmea_gga_position_parser.sv =====
// GGA sentence position parser: top level with stream ports.
// Instantiates ngga_parser and ngga_out_buf; uses ngga_pkg.
//
// Accepts one received character per cycle whenever in_tready is high. A character is
// processed in the cycle it is accepted, and any result it causes (a position at the
// comma closing the E/W field, or a search timeout) is pushed into the result
// register, or the skid entry while that register is full. The result side holds up to
// two results; input stalls only while both are waiting. The user must write the search
// limit through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
module nmea_gga_position_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [26:0] latitude, [57:27] longitude, [63:58] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic                   beat;
  logic                   res_valid;
  logic                   space;
  ngga_pkg::ngga_result_t res;
  ngga_pkg::ngga_result_t out_res;

  assign in_tready = space;
  assign beat      = in_tvalid && in_tready;

  ngga_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .rx_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  ngga_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {6'd0, out_res.longitude, out_res.latitude};

endmodule

// ===== rtl/ngga_checker.sv =====
// Port-level checker for nmea_gga_position_parser, attached by bind.
// Uses ngga_pkg status codes.
module ngga_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Only a waiting result can stall the input.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Non-ok results carry zero positions, and the padding is always zero.
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ngga_pkg::STAT_OK |-> out_tdata == 64'd0)
    else $error("non-ok result carries a position");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:58] == 6'd0)
    else $error("tdata padding not zero");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/nmea_gga_position_parser_tb.sv =====
// Self-checking testbench for the GGA position parser (nmea_gga_position_parser).
// Depends on ngga_pkg for character codes, status codes and the result layout;
// predicts each fix or search timeout from the accepted byte stream.
module nmea_gga_position_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_W  = 8'h57;

  // parser stages: hunting counts up from zero, then header seen, then inside sentence
  localparam int unsigned STG_IDLE   = 0;
  localparam int unsigned STG_DOLLAR = 1;
  localparam int unsigned STG_G1     = 2;
  localparam int unsigned STG_P      = 3;
  localparam int unsigned STG_G2     = 4;
  localparam int unsigned STG_G3     = 5;
  localparam int unsigned STG_HEADER = 6;
  localparam int unsigned STG_BODY   = 7;

  // comma-separated fields of a GGA sentence
  localparam int unsigned F_LAT = 1;
  localparam int unsigned F_NS  = 2;
  localparam int unsigned F_LON = 3;
  localparam int unsigned F_EW  = 4;
  localparam int unsigned F_END = 5;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam int LAT_W = ngga_pkg::LAT_W;
  localparam int LON_W = ngga_pkg::LON_W;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  nmea_gga_position_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Position predictor state
  // ---------------------------------------------------------------------------
  int unsigned  hunt_stage = STG_IDLE;
  int unsigned  hunt_bytes = 0;
  int unsigned  search_limit_q = 599;
  int unsigned  field_no;
  int unsigned  digit_cnt;
  longint       lat_deg, lat_min, lon_deg, lon_min;
  bit           north, east, lat_seen, lon_seen, bad_char;

  ngga_pkg::ngga_result_t pending_fixes[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  bit           sender_gaps = 1'b1;
  bit           stall_on = 1'b1;
  bit           ready_hold = 1'b0;

  function automatic void clear_fix();
    field_no  = 0;
    digit_cnt = 0;
    lat_deg   = 0;
    lat_min   = 0;
    lon_deg   = 0;
    lon_min   = 0;
    north     = 1'b1;
    east      = 1'b1;
    lat_seen  = 1'b0;
    lon_seen  = 1'b0;
    bad_char  = 1'b0;
  endfunction

  function automatic void add_digit(input int unsigned v, input int unsigned deg_w,
                                    inout longint deg, inout longint mins);
    if (digit_cnt < deg_w) deg = deg * 10 + v;
    else if (digit_cnt < deg_w + 6) mins = mins * 10 + v;
    if (digit_cnt < 15) digit_cnt++;
  endfunction

  // missing trailing digits keep their place value, i.e. count as zeros
  function automatic void scale_field(input int unsigned deg_w,
                                      inout longint deg, inout longint mins);
    int unsigned m;
    if (digit_cnt < deg_w) repeat (deg_w - digit_cnt) deg = deg * 10;
    m = (digit_cnt > deg_w) ? digit_cnt - deg_w : 0;
    if (m > 6) m = 6;
    repeat (6 - m) mins = mins * 10;
  endfunction

  function automatic int unsigned next_hunt_stage(input logic [7:0] c);
    if (c == ngga_pkg::CH_DOLLAR) return STG_DOLLAR;
    case (hunt_stage)
      STG_DOLLAR, STG_P, STG_G2: if (c == ngga_pkg::CH_G) return hunt_stage + 1;
      STG_G1:  if (c == ngga_pkg::CH_P) return STG_P;
      STG_G3:  if (c == ngga_pkg::CH_A) return STG_HEADER;
      default: ;
    endcase
    return STG_IDLE;
  endfunction

  function automatic bit sentence_byte(input logic [7:0] c,
                                       output ngga_pkg::ngga_result_t fix);
    longint lat, lon;
    fix = '0;
    if (c == ngga_pkg::CH_COMMA) begin
      if (field_no == F_LAT) scale_field(2, lat_deg, lat_min);
      else if (field_no == F_LON) scale_field(3, lon_deg, lon_min);
      field_no++;
      digit_cnt = 0;
      if (field_no < F_END) return 1'b0;
      if (!(lat_seen && lon_seen)) begin
        fix.status = ngga_pkg::STAT_UNAVAIL;
      end else if (bad_char) begin
        fix.status = ngga_pkg::STAT_BAD;
      end else begin
        fix.status = ngga_pkg::STAT_OK;
        lat = lat_deg * ngga_pkg::UNITS_PER_DEG + lat_min;
        lon = lon_deg * ngga_pkg::UNITS_PER_DEG + lon_min;
        if (!north) lat = -lat;
        if (!east) lon = -lon;
        fix.latitude  = lat[LAT_W-1:0];
        fix.longitude = lon[LON_W-1:0];
      end
      clear_fix();
      hunt_stage = STG_IDLE;
      hunt_bytes = 0;
      return 1'b1;
    end
    case (field_no)
      F_LAT, F_LON: begin
        if (c >= ngga_pkg::CH_ZERO && c <= ngga_pkg::CH_NINE) begin
          if (field_no == F_LAT) begin
            add_digit(32'(c - ngga_pkg::CH_ZERO), 2, lat_deg, lat_min);
            lat_seen = 1'b1;
          end else begin
            add_digit(32'(c - ngga_pkg::CH_ZERO), 3, lon_deg, lon_min);
            lon_seen = 1'b1;
          end
        end else if (c != ngga_pkg::CH_DOT) begin
          bad_char = 1'b1;
        end
      end
      F_NS:    north = (c == ngga_pkg::CH_N);
      F_EW:    east = (c == ngga_pkg::CH_E);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // advance the predictor by one received byte; returns 1 when a result is due
  function automatic bit gga_step(input logic [7:0] c, output ngga_pkg::ngga_result_t fix);
    fix = '0;
    if (hunt_stage >= STG_HEADER && c == ngga_pkg::CH_DOLLAR) hunt_stage = STG_IDLE;
    if (hunt_stage == STG_HEADER) begin
      if (c == ngga_pkg::CH_COMMA) begin
        clear_fix();
        hunt_stage = STG_BODY;
        return 1'b0;
      end
      hunt_stage = STG_IDLE;
    end
    if (hunt_stage == STG_BODY) return sentence_byte(c, fix);
    hunt_stage = next_hunt_stage(c);
    if (hunt_stage == STG_HEADER) begin
      hunt_bytes = 0;
      return 1'b0;
    end
    hunt_bytes++;
    if (hunt_bytes >= search_limit_q) begin
      hunt_bytes = 0;
      hunt_stage = STG_IDLE;
      fix.status = ngga_pkg::STAT_TIMEOUT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on input beats, compare on output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ngga_pkg::ngga_result_t fix;
    ngga_pkg::ngga_result_t want;
    if (rst_n) begin
      if (cfg_wr_en) search_limit_q = {16'd0, cfg_wr_data};
      if (in_tvalid && in_tready) begin
        if (gga_step(in_tdata, fix)) pending_fixes.push_back(fix);
      end
      if (out_tvalid && out_tready) begin
        if (pending_fixes.size() == 0) begin
          $error("unexpected result beat: status %0d tdata %h", out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = pending_fixes.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[LAT_W-1:0] !== want.latitude) begin
            $error("latitude: expected %0d, got %0d", $signed(want.latitude),
                   $signed(out_tdata[LAT_W-1:0]));
            mismatch_count++;
          end
          if (out_tdata[LAT_W+LON_W-1:LAT_W] !== want.longitude) begin
            $error("longitude: expected %0d, got %0d", $signed(want.longitude),
                   $signed(out_tdata[LAT_W+LON_W-1:LAT_W]));
            mismatch_count++;
          end
          if (out_tdata[63:LAT_W+LON_W] !== '0) begin
            $error("tdata pad: expected 0, got %h", out_tdata[63:LAT_W+LON_W]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (ready_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        ready_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 2) == 0) gap = idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // drop valid, let every predicted result arrive, then let the pipe settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= ngga_pkg::CH_ZERO && c <= ngga_pkg::CH_NINE) || c == ngga_pkg::CH_DOT ||
           c == ngga_pkg::CH_COMMA || c == ngga_pkg::CH_DOLLAR);
    return c;
  endfunction

  task automatic send_digits(input int unsigned n);
    repeat (n) send_byte(ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_position(input int unsigned deg_w);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 72) begin
      send_digits(deg_w + 2);
      send_byte(ngga_pkg::CH_DOT);
      send_digits($urandom_range(0, 6));
    end else if (mode < 84) begin
      repeat ($urandom_range(0, 14)) begin
        if ($urandom_range(0, 6) == 0) send_byte(ngga_pkg::CH_DOT);
        else send_digits(1);
      end
    end else if (mode < 90) begin
      // leave the field empty
    end else begin
      send_digits($urandom_range(0, 5));
      send_byte(odd_char());
      send_digits($urandom_range(0, 5));
    end
  endtask

  task automatic send_hemisphere(input logic [7:0] pos, input logic [7:0] neg);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) send_byte(pos);
    else if (r < 80) send_byte(neg);
    else if (r < 88) ;
    else if (r < 94) begin
      send_byte($urandom_range(0, 1) ? pos : neg);
      send_byte($urandom_range(0, 1) ? pos : neg);
    end else send_byte(8'($urandom_range(8'h41, 8'h5A)));
  endtask

  // one GGA sentence, mostly well formed, with random content and tail
  task automatic send_rand_sentence();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 84) send_str("$GPGGA,");
    else if (sel < 89) send_str("$GPRMC,");
    else if (sel < 95) begin
      send_str("$GPGGA");
      send_byte(8'($urandom_range(0, 255)));
    end else send_str("$GPG");
    send_digits($urandom_range(0, 6));
    if ($urandom_range(0, 1)) begin
      send_byte(ngga_pkg::CH_DOT);
      send_digits($urandom_range(0, 3));
    end
    send_byte(ngga_pkg::CH_COMMA);
    send_position(2);
    send_byte(ngga_pkg::CH_COMMA);
    send_hemisphere(ngga_pkg::CH_N, CH_S);
    send_byte(ngga_pkg::CH_COMMA);
    send_position(3);
    send_byte(ngga_pkg::CH_COMMA);
    send_hemisphere(ngga_pkg::CH_E, CH_W);
    if ($urandom_range(0, 9) != 0) send_byte(ngga_pkg::CH_COMMA);
    sel = $urandom_range(0, 99);
    if (sel < 45) send_str("1,08,0.9,545.4,M,46.9,M,,*47\r\n");
    else if (sel < 80) repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_fix();
    send_str("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
    send_str("$GPGGA,235959,9999.9999,N,99999.9999,E,");
    send_str("$GPGGA,000000,9999.9999,S,99999.9999,W,");
    send_str("$GPGGA,1,0000.0000,S,00000.0000,W,");
    send_str("$GPGGA,1,4299.9999,N,17960.0000,W,");
  endtask

  task automatic test_field_lengths();
    send_str("$GPGGA,1,4,N,1,E,");
    send_str("$GPGGA,1,48,S,011,E,");
    send_str("$GPGGA,1,4807.0,N,01131.00,W,");
    send_str("$GPGGA,1,4807.038123456,N,01131.00012345678,E,");
    send_str("$GPGGA,1,12345678901234567890,N,12345678901234567890,E,");
    send_str("$GPGGA,1,1.2.3.4,N,..5,E,");
  endtask

  task automatic test_status_codes();
    send_str("$GPGGA,1,,N,01131.000,E,");
    send_str("$GPGGA,1,4807.038,N,,E,");
    send_str("$GPGGA,1,..,N,01131.000,E,");
    send_str("$GPGGA,1,48x7.038,N,01131.000,E,");
    send_str("$GPGGA,1,4807.038,N,0113 1.000,E,");
    send_str("$GPGGA,1,x,N,01131.000,E,");
    send_str("$GPGGA,zz,4807.038,N,01131.000,E,");
  endtask

  task automatic test_hemisphere();
    send_str("$GPGGA,1,1234.5678,NS,01234.5678,EW,");
    send_str("$GPGGA,1,1234.5678,SN,01234.5678,WE,");
    send_str("$GPGGA,1,1234.5678,,01234.5678,,");
    send_str("$GPGGA,1,1234.5678,n,01234.5678,e,");
  endtask

  task automatic test_resync();
    send_str("$GPGGA,12,45$GPGGA,1,4807.038,N,01131.000,E,");
    send_str("$GP$GPGGA,,1111.1111,N,11111.1111,E,");
    send_str("$GPGGAX,1234,N,");
    send_str("$GPGGA$GPGGA,,0101.01,S,00101.01,W,");
    send_str("$GPRMC,123519,A,4807.038,N,01131.000,E,");
    send_str("$$GPGGA,,0202,N,00202,E,");
  endtask

  task automatic test_search_timeout();
    write_limit(16'd5);
    send_str("abcdefghijk");
    send_str("$GPGGA,1,4807.038,N,01131.000,E,");
    write_limit(16'd0);
    send_str("xyz");
    write_limit(16'd8);
    send_str("xxxx$GPGGA,1,4807.038,N,01131.000,E,");
    send_str("xxxxxxxxx");
    write_limit(16'd65535);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_str("$GPGGA,1,4807.038,N,01131.000,E,");
    write_limit(16'd599);
  endtask

  // every byte times out at a limit of one, so the result side fills up fast
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    write_limit(16'd1);
    ready_hold = 1'b1;
    while (out_tready) @(posedge clk);
    repeat (24) send_byte(8'($urandom_range(0, 255)));
    while (ready_hold) @(posedge clk);
    write_limit(16'd599);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned start;
    int unsigned budget;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_limit(16'd599);
          budget = 40; sender_gaps = 1'b1; stall_on = 1'b1;
        end
        1: begin
          write_limit(16'd65535);
          budget = 30; sender_gaps = 1'b0; stall_on = 1'b0;
        end
        2: begin
          write_limit(16'd30);
          budget = 30; sender_gaps = 1'b1; stall_on = 1'b0;
        end
        3: begin
          write_limit(16'($urandom_range(6, 120)));
          budget = 30; sender_gaps = 1'b0; stall_on = 1'b1;
        end
        default: begin
          write_limit(16'd2);
          budget = 20; sender_gaps = 1'b1; stall_on = 1'b1;
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < budget) send_rand_sentence();
    end
  endtask

  initial begin
    clear_fix();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_fix();
    test_field_lengths();
    test_status_codes();
    test_hemisphere();
    test_resync();
    test_search_timeout();
    test_backpressure();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
